/* design/mfrf_pkg.sv */
package mfrf_pkg;

  // screen geometry
  localparam int SCREEN_WIDTH  = 200;
  localparam int SCREEN_HEIGHT = 200;
  localparam int ROW_BYTES     = 25;

  localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
  localparam int VIS_WIDTH   = (SCREEN_WIDTH < ROW_BYTES * 8) ? SCREEN_WIDTH : ROW_BYTES * 8;

  // derived widths
  localparam int X_W    = ($clog2(VIS_WIDTH) > 4) ? $clog2(VIS_WIDTH) : 4;
  localparam int Y_W    = ($clog2(SCREEN_HEIGHT) > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam int BC_W   = X_W - 3;
  localparam int ADDR_W = ($clog2(STORE_BYTES) > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int PROD_W = (X_W + Y_W + 2 > 17) ? X_W + Y_W + 2 : 17;

  // pixel count of a full-screen fill, saturated
  localparam int FILL_PIX = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam logic [15:0] FILL_COUNT = (FILL_PIX > 65535) ? 16'hffff : 16'(FILL_PIX);
  localparam logic [15:0] COUNT_MAX  = 16'hffff;

  // command queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // request codes
  localparam logic [1:0] REQ_FILL  = 2'd0;
  localparam logic [1:0] REQ_PIXEL = 2'd1;
  localparam logic [1:0] REQ_RECT  = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // byte values
  localparam logic [7:0] BYTE_WHITE = 8'hff;
  localparam logic [7:0] BYTE_BLACK = 8'h00;

  // work classes handed from front to back
  typedef enum logic [1:0] {
    OP_NONE,
    OP_FILL,
    OP_RECT,
    OP_READ
  } op_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CLIP,
    F_PUSH
  } f_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_FILL,
    B_RUN,
    B_DRAIN,
    B_RESULT
  } b_state_t;

  // one classified command
  typedef struct packed {
    op_t               op;
    logic              status;
    logic [15:0]       count;
    logic              black;
    logic [X_W-1:0]    x0;
    logic [X_W-1:0]    x1;
    logic [Y_W-1:0]    y0;
    logic [Y_W-1:0]    y1;
    logic [ADDR_W-1:0] base;
  } cmd_t;

endpackage

/* design/mfrf_front.sv */
module mfrf_front import mfrf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] rect_width,
  input  logic signed [15:0] rect_height,
  input  logic               paint_black,
  input  logic               init_done,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               q_entry
);

  localparam logic signed [17:0] VIS18 = 18'(VIS_WIDTH);
  localparam logic signed [17:0] SH18  = 18'(SCREEN_HEIGHT);

  f_state_t fstate, fstate_next;

  // captured request
  logic [1:0]         req_r;
  logic signed [15:0] x_r, y_r, w_r, h_r;
  logic               black_r;

  // clipped request
  op_t            op_c;
  logic           status_c;
  logic           black_c;
  logic [X_W-1:0] x0_c, x1_c;
  logic [Y_W-1:0] y0_c, y1_c;
  logic [X_W:0]   span_w_c;
  logic [Y_W:0]   span_h_c;

  // clipping terms
  logic signed [17:0] xs, ys, ws, hs;
  logic signed [17:0] left, right, top, bottom;
  logic signed [17:0] rsum, bsum;
  logic               on_scr, rect_ok;
  op_t                op_n;
  logic               status_n;
  logic signed [17:0] right_m1, bottom_m1, span_w18, span_h18;

  // count and row base
  logic [PROD_W-1:0] prod;
  logic [15:0]       count;

  assign in_ready = (fstate == F_IDLE) && init_done;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
    end else begin
      fstate <= fstate_next;
    end
  end

  // next state
  always_comb begin
    fstate_next = fstate;
    q_push      = 1'b0;
    case (fstate)
      F_IDLE: begin
        if (in_valid && in_ready) fstate_next = F_CLIP;
      end
      F_CLIP: begin
        fstate_next = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push      = 1'b1;
          fstate_next = F_IDLE;
        end
      end
      default: fstate_next = F_IDLE;
    endcase
  end

  // clip against the visible area
  always_comb begin
    xs   = 18'(x_r);
    ys   = 18'(y_r);
    ws   = 18'(w_r);
    hs   = 18'(h_r);
    rsum = xs + ws;
    bsum = ys + hs;
    on_scr = (xs >= 0) && (xs < VIS18) && (ys >= 0) && (ys < SH18);
    left   = xs;
    right  = xs + 18'sd1;
    top    = ys;
    bottom = ys + 18'sd1;
    rect_ok  = 1'b0;
    op_n     = OP_NONE;
    status_n = 1'b1;
    case (req_r)
      REQ_FILL: begin
        op_n     = OP_FILL;
        status_n = 1'b0;
      end
      REQ_PIXEL: begin
        op_n     = on_scr ? OP_RECT : OP_NONE;
        status_n = !on_scr;
      end
      REQ_RECT: begin
        left    = (xs < 0) ? 18'sd0 : xs;
        top     = (ys < 0) ? 18'sd0 : ys;
        right   = (rsum > VIS18) ? VIS18 : rsum;
        bottom  = (bsum > SH18) ? SH18 : bsum;
        rect_ok = (ws > 0) && (hs > 0) && (left < right) && (top < bottom);
        op_n     = rect_ok ? OP_RECT : OP_NONE;
        status_n = !rect_ok;
      end
      REQ_READ: begin
        op_n     = on_scr ? OP_READ : OP_NONE;
        status_n = !on_scr;
      end
      default: begin
        op_n     = OP_NONE;
        status_n = 1'b1;
      end
    endcase
    right_m1  = right - 18'sd1;
    bottom_m1 = bottom - 18'sd1;
    span_w18  = right - left;
    span_h18  = bottom - top;
  end

  // capture and clip registers
  always_ff @(posedge clk) begin
    if (fstate == F_IDLE && in_valid && in_ready) begin
      req_r   <= req_type;
      x_r     <= pos_x;
      y_r     <= pos_y;
      w_r     <= rect_width;
      h_r     <= rect_height;
      black_r <= paint_black;
    end
    if (fstate == F_CLIP) begin
      op_c     <= op_n;
      status_c <= status_n;
      black_c  <= black_r;
      x0_c     <= left[X_W-1:0];
      x1_c     <= right_m1[X_W-1:0];
      y0_c     <= top[Y_W-1:0];
      y1_c     <= bottom_m1[Y_W-1:0];
      span_w_c <= span_w18[X_W:0];
      span_h_c <= span_h18[Y_W:0];
    end
  end

  // pixel count, saturated
  always_comb begin
    prod = PROD_W'(span_w_c) * PROD_W'(span_h_c);
    case (op_c)
      OP_FILL: count = FILL_COUNT;
      OP_RECT: count = (prod > PROD_W'(COUNT_MAX)) ? COUNT_MAX : prod[15:0];
      default: count = 16'd0;
    endcase
  end

  // queue entry
  always_comb begin
    q_entry.op     = op_c;
    q_entry.status = status_c;
    q_entry.count  = count;
    q_entry.black  = black_c;
    q_entry.x0     = x0_c;
    q_entry.x1     = x1_c;
    q_entry.y0     = y0_c;
    q_entry.y1     = y1_c;
    q_entry.base   = ADDR_W'(ADDR_W'(y0_c) * ADDR_W'(ROW_BYTES));
  end

endmodule

/* design/mfrf_queue.sv */
module mfrf_queue import mfrf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full  = (fill == (QPTR_W + 1)'(QDEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        fill <= fill + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* design/mfrf_back.sv */
module mfrf_back import mfrf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        q_head,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        init_done,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic [15:0] pixels_written,
  output logic [7:0]  read_data
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

  b_state_t state, state_next;

  // frame store
  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rdata;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  // sweep state
  cmd_t              cmd;
  logic [ADDR_W-1:0] fill_addr;
  logic [Y_W-1:0]    row;
  logic [BC_W-1:0]   bc;
  logic [ADDR_W-1:0] row_base;
  logic [7:0]        res_data;
  logic              load_out;

  // pending read-modify-write
  logic              pend_valid;
  logic [ADDR_W-1:0] pend_addr;
  logic [7:0]        pend_mask;

  // byte mask of the current byte
  logic [BC_W-1:0]   lb, rb;
  logic [2:0]        s_bit, e_bit;
  logic [7:0]        mask;
  logic [ADDR_W-1:0] cur_addr;
  logic              row_end, last_byte, fill_last;

  assign init_done = (state != B_CLEAR);
  assign lb        = cmd.x0[X_W-1:3];
  assign rb        = cmd.x1[X_W-1:3];
  assign s_bit     = (bc == lb) ? cmd.x0[2:0] : 3'd0;
  assign e_bit     = (bc == rb) ? cmd.x1[2:0] : 3'd7;
  assign mask      = (8'hff >> s_bit) & (8'hff << (3'd7 - e_bit));
  assign cur_addr  = row_base + ADDR_W'(bc);
  assign row_end   = (bc == rb);
  assign last_byte = row_end && (row == cmd.y1);
  assign fill_last = (fill_addr == LAST_ADDR);

  // write port select
  always_comb begin
    if (state == B_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = fill_addr;
      wr_data = BYTE_WHITE;
    end else if (state == B_FILL) begin
      wr_en   = 1'b1;
      wr_addr = fill_addr;
      wr_data = cmd.black ? BYTE_BLACK : BYTE_WHITE;
    end else begin
      wr_en   = pend_valid;
      wr_addr = pend_addr;
      wr_data = cmd.black ? (rdata & ~pend_mask) : (rdata | pend_mask);
    end
  end

  // store ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[cur_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_out   = 1'b0;
    case (state)
      B_CLEAR: begin
        if (fill_last) state_next = B_IDLE;
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_head.op)
            OP_NONE: state_next = B_RESULT;
            OP_FILL: state_next = B_FILL;
            default: state_next = B_RUN;
          endcase
        end
      end
      B_FILL: begin
        if (fill_last) state_next = B_RESULT;
      end
      B_RUN: begin
        if (last_byte) state_next = B_DRAIN;
      end
      B_DRAIN: begin
        state_next = B_RESULT;
      end
      B_RESULT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_CLEAR;
      fill_addr  <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= (state == B_RUN) && (cmd.op != OP_READ);
      if (state == B_CLEAR || state == B_FILL) begin
        fill_addr <= fill_last ? '0 : fill_addr + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sweep and result registers
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          cmd      <= q_head;
          row      <= q_head.y0;
          bc       <= q_head.x0[X_W-1:3];
          row_base <= q_head.base;
          res_data <= BYTE_BLACK;
        end
      end
      B_RUN: begin
        pend_addr <= cur_addr;
        pend_mask <= mask;
        if (row_end) begin
          bc       <= lb;
          row      <= row + 1'b1;
          row_base <= row_base + ADDR_W'(ROW_BYTES);
        end else begin
          bc <= bc + 1'b1;
        end
      end
      B_DRAIN: begin
        if (cmd.op == OP_READ) res_data <= rdata;
      end
      default: begin
      end
    endcase
    if (load_out) begin
      status         <= cmd.status;
      pixels_written <= cmd.count;
      read_data      <= res_data;
    end
  end

endmodule

/* design/mono_framebuffer_rect_fill_core.sv */
// channel | handshake            | word
// --------+----------------------+----------------------------------------------
// in      | in_valid / in_ready  | req_type pos_x pos_y rect_width rect_height
//         |                      | paint_black
// out     | out_valid / out_ready| status pixels_written read_data
//
// after reset a clearing pass writes white to all STORE_BYTES (5000) bytes, one per
// cycle; no word is taken until it is done
// the front clips, then counts and pushes; a 2-entry queue lets it run ahead of the back
// back: a screen fill writes all STORE_BYTES bytes, one per cycle; a rectangle sweeps each
// byte touched (rows times bytes per row) through the single read-modify-write port
// pixel and read words pass B_RUN and B_DRAIN; ignored words go straight to B_RESULT
// a stalled out channel holds one finished word; the back waits, the front fills the queue
module mono_framebuffer_rect_fill_core import mfrf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] rect_width,
  input  logic signed [15:0] rect_height,
  input  logic               paint_black,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               status,
  output logic [15:0]        pixels_written,
  output logic [7:0]         read_data
);

  logic init_done;
  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_entry, q_head;

  // classify and clip
  mfrf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .paint_black (paint_black),
    .init_done   (init_done),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_entry)
  );

  // command queue
  mfrf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // frame store sequencer
  mfrf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_head         (q_head),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .init_done      (init_done),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .pixels_written (pixels_written),
    .read_data      (read_data)
  );

endmodule

/* sim/mono_framebuffer_rect_fill_core_tb.sv */
module mono_framebuffer_rect_fill_core_tb import mfrf_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 11;
  localparam int IDLE_LIMIT   = 40000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_WORDS = 80;
  localparam int PRESS_WORDS  = 14;

  typedef enum int {
    PH_SMOOTH,
    PH_SRC_GAPS,
    PH_SNK_STALLS,
    PH_BOTH,
    PH_PRESSURE
  } phase_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
    logic               black;
  } request_t;

  typedef struct packed {
    logic        status;
    logic [15:0] count;
    logic [7:0]  data;
  } result_t;

  typedef struct packed {
    request_t req;
    logic     known;
    result_t  res;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         req_type = REQ_READ;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;
  logic signed [15:0] rect_width = '0;
  logic signed [15:0] rect_height = '0;
  logic               paint_black = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               status;
  logic [15:0]        pixels_written;
  logic [7:0]         read_data;

  // shadow copy of the frame store and the words still owed by the block
  logic [7:0] shadow_frame [STORE_BYTES];
  result_t    pending_results [$];
  dir_row_t   steps [$];

  phase_t phase = PH_SMOOTH;
  int     src_idle_pct = 0;
  int     snk_stall_pct = 0;
  int     big_budget = 5;
  int     n_fail = 0;
  int     n_checked = 0;
  int     kind_seen [4] = '{0, 0, 0, 0};
  int     idle_cycles = 0;
  int     hold_cnt = 0;
  bit     hold_done = 1'b0;

  mono_framebuffer_rect_fill_core uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit visible(int x, int y);
    return x >= 0 && y >= 0 && x < VIS_WIDTH && y < SCREEN_HEIGHT;
  endfunction

  function automatic void plot(int x, int y, logic black);
    int          idx;
    logic [7:0]  mask;
    idx  = y * ROW_BYTES + x / 8;
    mask = 8'h80 >> (x % 8);
    if (black) shadow_frame[idx] &= ~mask;
    else shadow_frame[idx] |= mask;
  endfunction

  function automatic logic [15:0] clamp_count(int n);
    return (n > 65535) ? COUNT_MAX : 16'(n);
  endfunction

  // expected word for one request, updating the shadow store
  function automatic result_t apply_request(request_t r);
    result_t res;
    int      x, y, w, h;
    int      left, top, right, bottom;
    x   = int'(r.x);
    y   = int'(r.y);
    w   = int'(r.w);
    h   = int'(r.h);
    res = '{status: 1'b1, count: '0, data: '0};
    case (r.kind)
      REQ_FILL: begin
        foreach (shadow_frame[i]) shadow_frame[i] = r.black ? BYTE_BLACK : BYTE_WHITE;
        res.status = 1'b0;
        res.count  = clamp_count(SCREEN_WIDTH * SCREEN_HEIGHT);
      end
      REQ_PIXEL: begin
        if (visible(x, y)) begin
          plot(x, y, r.black);
          res.status = 1'b0;
          res.count  = 16'd1;
        end
      end
      REQ_RECT: begin
        if (w > 0 && h > 0) begin
          left   = (x < 0) ? 0 : x;
          top    = (y < 0) ? 0 : y;
          right  = (x + w > VIS_WIDTH) ? VIS_WIDTH : x + w;
          bottom = (y + h > SCREEN_HEIGHT) ? SCREEN_HEIGHT : y + h;
          if (left < right && top < bottom) begin
            for (int row = top; row < bottom; row++)
              for (int col = left; col < right; col++) plot(col, row, r.black);
            res.status = 1'b0;
            res.count  = clamp_count((right - left) * (bottom - top));
          end
        end
      end
      default: begin
        if (visible(x, y)) begin
          res.data   = shadow_frame[y * ROW_BYTES + x / 8];
          res.status = 1'b0;
        end
      end
    endcase
    return res;
  endfunction

  function automatic void add_step(logic [1:0] kind, int x, int y, int w, int h,
                                   logic black, logic known = 1'b0, logic st = 1'b0,
                                   int cnt = 0, logic [7:0] data = '0);
    dir_row_t row;
    row.req   = '{kind: kind, x: 16'(x), y: 16'(y), w: 16'(w), h: 16'(h), black: black};
    row.known = known;
    row.res   = '{status: st, count: 16'(cnt), data: data};
    steps.push_back(row);
  endfunction

  // random request: mostly on or near the screen, some full-range noise
  function automatic request_t random_request();
    request_t r;
    int       pick;
    pick    = $urandom_range(99);
    r.kind  = 2'($urandom_range(3));
    r.x     = 16'($urandom);
    r.y     = 16'($urandom);
    r.w     = 16'($urandom);
    r.h     = 16'($urandom);
    r.black = 1'($urandom_range(1));
    if (pick < 8) begin
      if (r.kind inside {REQ_FILL, REQ_RECT}) begin
        if (big_budget > 0) big_budget--;
        else r.kind = REQ_PIXEL;
      end
    end else if (pick < 64) begin
      r.kind = (pick < 36) ? REQ_PIXEL : REQ_READ;
      r.x    = 16'(int'($urandom_range(VIS_WIDTH + 1)) - 1);
      r.y    = 16'(int'($urandom_range(SCREEN_HEIGHT + 1)) - 1);
    end else if (pick < 97 || big_budget == 0) begin
      r.kind = REQ_RECT;
      r.x    = 16'(int'($urandom_range(VIS_WIDTH + 8)) - 8);
      r.y    = 16'(int'($urandom_range(SCREEN_HEIGHT + 8)) - 8);
      r.w    = 16'(int'($urandom_range(26)) - 2);
      r.h    = 16'(int'($urandom_range(14)) - 2);
    end else begin
      big_budget--;
      r.kind = $urandom_range(1) ? REQ_FILL : REQ_RECT;
      r.x    = 16'(int'($urandom_range(40)) - 20);
      r.y    = 16'(int'($urandom_range(40)) - 20);
      r.w    = 16'($urandom_range(32767, VIS_WIDTH));
      r.h    = 16'($urandom_range(32767, SCREEN_HEIGHT));
    end
    return r;
  endfunction

  // offer one word, wait for it to be taken, then queue its expected result
  task automatic send_request(request_t r, logic known, result_t typed);
    result_t want;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= r.kind;
    pos_x       <= r.x;
    pos_y       <= r.y;
    rect_width  <= r.w;
    rect_height <= r.h;
    paint_black <= r.black;
    do @(posedge clk); while (!in_ready);
    want = apply_request(r);
    pending_results.push_back(known ? typed : want);
    kind_seen[r.kind]++;
  endtask

  // receiver: random stalls, plus one long hold-off in the pressure phase
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt - 1;
    end else if (phase == PH_PRESSURE && !hold_done) begin
      out_ready <= 1'b0;
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // compare each delivered word against the oldest expectation
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: status %0d count %0d data 0x%02h",
               status, pixels_written, read_data);
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, status);
          n_fail++;
        end
        if (pixels_written !== want.count) begin
          $error("pixels_written mismatch: expected %0d, actual %0d",
                 want.count, pixels_written);
          n_fail++;
        end
        if (read_data !== want.data) begin
          $error("read_data mismatch: expected 0x%02h, actual 0x%02h", want.data, read_data);
          n_fail++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", idle_cycles);
      $display("mono_framebuffer_rect_fill_core_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (shadow_frame[i]) shadow_frame[i] = BYTE_WHITE;

    // reads after reset, screen edges and just past them
    add_step(REQ_READ, 0, 0, 0, 0, 1'b0, 1'b1, 1'b0, 0, BYTE_WHITE);
    add_step(REQ_READ, -1, 0, 0, 0, 1'b1, 1'b1, 1'b1, 0, 8'h00);
    add_step(REQ_READ, VIS_WIDTH - 1, SCREEN_HEIGHT - 1, 0, 0, 1'b0, 1'b1, 1'b0, 0, BYTE_WHITE);
    add_step(REQ_READ, VIS_WIDTH, 0, 0, 0, 1'b0, 1'b1, 1'b1, 0, 8'h00);
    add_step(REQ_READ, 0, SCREEN_HEIGHT, 0, 0, 1'b0, 1'b1, 1'b1, 0, 8'h00);
    // pixels in the corners, and off screen at the field extremes
    add_step(REQ_PIXEL, 0, 0, 0, 0, 1'b1, 1'b1, 1'b0, 1);
    add_step(REQ_READ, 0, 0, 0, 0, 1'b0, 1'b1, 1'b0, 0, 8'h7f);
    add_step(REQ_PIXEL, VIS_WIDTH - 1, SCREEN_HEIGHT - 1, 0, 0, 1'b1, 1'b1, 1'b0, 1);
    add_step(REQ_READ, VIS_WIDTH - 1, SCREEN_HEIGHT - 1, 0, 0, 1'b0, 1'b1, 1'b0, 0, 8'hfe);
    add_step(REQ_PIXEL, -32768, 0, -1, -1, 1'b1, 1'b1, 1'b1, 0);
    add_step(REQ_PIXEL, 32767, 32767, 32767, 32767, 1'b0, 1'b1, 1'b1, 0);
    // empty rectangles, and ones clipped away
    add_step(REQ_RECT, 10, 10, 0, 5, 1'b1, 1'b1, 1'b1, 0);
    add_step(REQ_RECT, 10, 10, 5, -32768, 1'b1, 1'b1, 1'b1, 0);
    add_step(REQ_RECT, VIS_WIDTH, 0, 10, 10, 1'b1, 1'b1, 1'b1, 0);
    add_step(REQ_RECT, -32768, -32768, 32767, 32767, 1'b1, 1'b1, 1'b1, 0);
    add_step(REQ_RECT, -5, -5, 10, 3, 1'b1, 1'b1, 1'b1, 0);
    // small rectangle straddling a byte boundary
    add_step(REQ_RECT, 3, 2, 10, 4, 1'b1, 1'b1, 1'b0, 40);
    add_step(REQ_READ, 8, 3, 0, 0, 1'b0);
    add_step(REQ_READ, 0, 2, 0, 0, 1'b1);
    // rectangle clipped to the whole screen, then fills both ways
    add_step(REQ_RECT, -10, -10, 32767, 32767, 1'b0, 1'b1, 1'b0,
             SCREEN_WIDTH * SCREEN_HEIGHT);
    add_step(REQ_FILL, -1, -1, -1, -1, 1'b1, 1'b1, 1'b0, SCREEN_WIDTH * SCREEN_HEIGHT);
    add_step(REQ_READ, 100, 100, 0, 0, 1'b0, 1'b1, 1'b0, 0, BYTE_BLACK);
    add_step(REQ_PIXEL, 9, 1, 0, 0, 1'b0);
    add_step(REQ_FILL, 0, 0, 0, 0, 1'b0, 1'b1, 1'b0, SCREEN_WIDTH * SCREEN_HEIGHT);
    add_step(REQ_READ, 7, 0, 0, 0, 1'b0, 1'b1, 1'b0, 0, BYTE_WHITE);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed table, no idling
    foreach (steps[i]) send_request(steps[i].req, steps[i].known, steps[i].res);

    // random words over four idle mixes
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      case (i / (RANDOM_WORDS / 4))
        0: begin phase <= PH_SMOOTH;     src_idle_pct = 0;  snk_stall_pct <= 0;  end
        1: begin phase <= PH_SRC_GAPS;   src_idle_pct = 57; snk_stall_pct <= 0;  end
        2: begin phase <= PH_SNK_STALLS; src_idle_pct = 0;  snk_stall_pct <= 57; end
        default: begin phase <= PH_BOTH; src_idle_pct = 6;  snk_stall_pct <= 6;  end
      endcase
      send_request(random_request(), 1'b0, '0);
    end

    // back-to-back pixels while the receiver holds off, to fill the queue
    phase <= PH_PRESSURE;
    src_idle_pct = 0;
    snk_stall_pct <= 0;
    for (int i = 0; i < PRESS_WORDS; i++)
      send_request('{kind: REQ_PIXEL, x: 16'($urandom_range(VIS_WIDTH - 1)),
                     y: 16'($urandom_range(SCREEN_HEIGHT - 1)), w: '0, h: '0,
                     black: 1'($urandom_range(1))}, 1'b0, '0);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d fill, %0d pixel, %0d rect and %0d read words; %0d results checked",
             kind_seen[REQ_FILL], kind_seen[REQ_PIXEL], kind_seen[REQ_RECT],
             kind_seen[REQ_READ], n_checked);
    $display("idle mixes: none, sender gaps, receiver stalls, light on both, one long hold-off");
    if (n_fail == 0) $display("mono_framebuffer_rect_fill_core_tb passed");
    else $display("mono_framebuffer_rect_fill_core_tb failed");
    $finish;
  end

endmodule

/* mono_framebuffer_rect_fill_core.f */
design/mfrf_pkg.sv
design/mfrf_front.sv
design/mfrf_queue.sv
design/mfrf_back.sv
design/mono_framebuffer_rect_fill_core.sv
sim/mono_framebuffer_rect_fill_core_tb.sv
